// ----- hw/rtl/ttq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_pkg
// Shared types, codes and defaults for the tagged timer queue.
// ----------------------------------------------------------------------------
package ttq_pkg;

    localparam int unsigned DefEntries  = 16;
    localparam int unsigned DefTimeBits = 48;
    localparam int unsigned DefTagBits  = 16;
    localparam int unsigned MaxResults  = 16;

    localparam int unsigned FuncBits = 3;
    localparam int unsigned KindBits = 3;
    localparam int unsigned IdBits   = 32;
    localparam int unsigned OutTime  = 48;

    localparam logic [FuncBits-1:0] FUNC_AT      = 3'd0;
    localparam logic [FuncBits-1:0] FUNC_KEEP    = 3'd1;
    localparam logic [FuncBits-1:0] FUNC_REPLACE = 3'd2;
    localparam logic [FuncBits-1:0] FUNC_CANCEL  = 3'd3;
    localparam logic [FuncBits-1:0] FUNC_TICK    = 3'd4;
    localparam logic [FuncBits-1:0] FUNC_QUERY   = 3'd5;

    localparam logic [KindBits-1:0] KIND_NEW     = 3'd0;
    localparam logic [KindBits-1:0] KIND_EXIST   = 3'd1;
    localparam logic [KindBits-1:0] KIND_FULL    = 3'd2;
    localparam logic [KindBits-1:0] KIND_EXPIRED = 3'd3;
    localparam logic [KindBits-1:0] KIND_QUERY   = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input transaction
        logic scan_clr;    // reset scan accumulators and index
        logic scan_step;   // examine one slot
        logic do_remove;   // invalidate the found id/min slot
        logic do_insert;   // write new timer into free slot
        logic out_load;    // load output register
        logic [KindBits-1:0] out_kind;
        logic out_last;
        logic clr_ticks;   // start of transaction: reset emit and expired counters
    } ttq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FuncBits-1:0] func;
        logic scan_done;
        logic tag_hit;
        logic id_hit;
        logic free_found;
        logic min_found;
        logic exp_last;    // next expired result is the last of this tick
    } ttq_stat_t;

endpackage

// ----- hw/rtl/ttq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_ctrl
// Sequencer: accepts a transaction, drives slot scans, issues results.
// ----------------------------------------------------------------------------
module ttq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_busy,
    input  ttq_pkg::ttq_stat_t stat,
    output ttq_pkg::ttq_cmd_t  cmd
);
    import ttq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACT  = 5'b00100,
        S_EMIT = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    cmd.clr_ticks = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                // output register must be free before a result is loaded
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                    case (stat.func)
                        FUNC_AT, FUNC_KEEP, FUNC_REPLACE:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.func == FUNC_KEEP && stat.tag_hit)
                            begin
                                cmd.out_kind = KIND_EXIST;
                            end
                            else if (stat.free_found)
                            begin
                                cmd.out_kind = KIND_NEW;
                                cmd.do_insert = 1'b1;
                            end
                            else
                            begin
                                cmd.out_kind = KIND_FULL;
                            end
                        end
                        FUNC_CANCEL:
                        begin
                            cmd.do_remove = stat.id_hit;
                        end
                        FUNC_TICK:
                        begin
                            if (stat.min_found)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_EXPIRED;
                                cmd.out_last = stat.exp_last;
                                cmd.do_remove = 1'b1;
                                state_next = S_EMIT;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            cmd.out_kind = KIND_QUERY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                // rescan to select the next expired timer
                cmd.scan_clr = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_ACT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ttq_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_dp
// Datapath: slot table, serial slot scan, id counter, output register.
// ----------------------------------------------------------------------------
module ttq_dp #(
    parameter int unsigned ENTRIES   = ttq_pkg::DefEntries,
    parameter int unsigned TIME_BITS = ttq_pkg::DefTimeBits,
    parameter int unsigned TAG_BITS  = ttq_pkg::DefTagBits
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ttq_pkg::FuncBits-1:0] func,
    input  logic [TIME_BITS-1:0]         now_time,
    input  logic [TIME_BITS-1:0]         time_arg,
    input  logic [TAG_BITS-1:0]          tag_key,
    input  logic [ttq_pkg::IdBits-1:0]   cancel_id,
    input  ttq_pkg::ttq_cmd_t            cmd,
    output ttq_pkg::ttq_stat_t           stat,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic                         out_busy,
    output logic [ttq_pkg::KindBits-1:0] kind,
    output logic [ttq_pkg::IdBits-1:0]   timer_id,
    output logic                         queue_empty,
    output logic [ttq_pkg::OutTime-1:0]  remaining,
    output logic                         last
);
    import ttq_pkg::*;

    localparam int unsigned IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CntBits = $clog2(ENTRIES + 1);
    localparam int unsigned EmitBits = $clog2(MaxResults + 1);
    localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

    logic [ENTRIES-1:0]   valid_reg;
    logic [TIME_BITS-1:0] dl_reg  [ENTRIES];
    logic [IdBits-1:0]    id_reg  [ENTRIES];
    logic [TAG_BITS-1:0]  tag_reg [ENTRIES];
    logic [IdBits-1:0]    last_id_reg;

    logic [FuncBits-1:0]  func_reg;
    logic [TIME_BITS-1:0] now_reg, targ_reg;
    logic [TAG_BITS-1:0]  tagk_reg;
    logic [IdBits-1:0]    cid_reg;

    logic [CntBits-1:0]   scan_reg;
    logic                 tag_hit_reg, id_hit_reg, free_reg, min_reg;
    logic [IdxBits-1:0]   tag_idx_reg, id_idx_reg, free_idx_reg, min_idx_reg;
    logic [EmitBits-1:0]  emit_reg;
    logic [CntBits-1:0]   exp_cnt_reg;

    logic                 ov_reg;
    logic [KindBits-1:0]  kind_reg;
    logic [IdBits-1:0]    tid_reg;
    logic                 empty_reg, last_reg;
    logic [OutTime-1:0]   rem_reg;

    logic [IdxBits-1:0]   sidx;
    logic                 sv;
    logic [TIME_BITS-1:0] sdl;
    logic [IdBits-1:0]    sid;
    logic [TAG_BITS-1:0]  stag;
    logic                 better;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] sat_dl, new_dl;
    logic [IdBits-1:0]    new_id;
    logic [TIME_BITS-1:0] mdl;
    logic [TIME_BITS-1:0] rem_full;
    logic                 is_tick;
    logic                 repl_hit;
    logic [IdxBits-1:0]   ins_idx;

    assign sidx = scan_reg[IdxBits-1:0];
    assign sv   = valid_reg[sidx];
    assign sdl  = dl_reg[sidx];
    assign sid  = id_reg[sidx];
    assign stag = tag_reg[sidx];
    assign mdl  = dl_reg[min_idx_reg];
    assign is_tick = (func_reg == FUNC_TICK);

    always_comb
    begin
        better = 1'b0;
        if (sv && (!is_tick || sdl <= now_reg))
        begin
            if (!min_reg || sdl < mdl)
            begin
                better = 1'b1;
            end
            else if (is_tick && sdl == mdl && sid < id_reg[min_idx_reg])
            begin
                better = 1'b1;
            end
        end
    end

    assign sum    = {1'b0, now_reg} + {1'b0, targ_reg};
    assign sat_dl = sum[TIME_BITS] ? TimeMax : sum[TIME_BITS-1:0];
    assign new_dl = (func_reg == FUNC_AT) ? targ_reg : sat_dl;
    assign new_id = (last_id_reg == '1) ? IdBits'(1) : last_id_reg + IdBits'(1);
    assign rem_full = (min_reg && mdl > now_reg) ? (mdl - now_reg) : '0;

    // replaced timer frees its slot; the new one takes the lowest free slot
    assign repl_hit = (func_reg == FUNC_REPLACE) && tag_hit_reg;
    assign ins_idx  = (repl_hit && (!free_reg || tag_idx_reg < free_idx_reg))
                      ? tag_idx_reg : free_idx_reg;

    assign stat.func       = func_reg;
    assign stat.scan_done  = (scan_reg == CntBits'(ENTRIES - 1));
    assign stat.tag_hit    = tag_hit_reg;
    assign stat.id_hit     = id_hit_reg;
    assign stat.free_found = free_reg || repl_hit;
    assign stat.min_found  = min_reg && (emit_reg != EmitBits'(MaxResults));
    assign stat.exp_last   = (32'(exp_cnt_reg) >= MaxResults)
                             ? (32'(emit_reg) + 32'd1 == MaxResults)
                             : (32'(emit_reg) + 32'd1 == 32'(exp_cnt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            now_reg  <= now_time;
            targ_reg <= time_arg;
            tagk_reg <= tag_key;
            cid_reg  <= cancel_id;
        end
        if (cmd.do_insert)
        begin
            dl_reg[ins_idx]  <= new_dl;
            id_reg[ins_idx]  <= new_id;
            tag_reg[ins_idx] <= (func_reg == FUNC_AT) ? '0 : tagk_reg;
        end
        if (cmd.scan_clr)
        begin
            tag_idx_reg  <= '0;
            id_idx_reg   <= '0;
            free_idx_reg <= '0;
            min_idx_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (sv && tagk_reg != '0 && stag == tagk_reg && !tag_hit_reg)
            begin
                tag_idx_reg <= sidx;
            end
            if (sv && sid == cid_reg && !id_hit_reg)
            begin
                id_idx_reg <= sidx;
            end
            if (!sv && !free_reg)
            begin
                free_idx_reg <= sidx;
            end
            if (better)
            begin
                min_idx_reg <= sidx;
            end
        end
        if (cmd.out_load)
        begin
            kind_reg  <= cmd.out_kind;
            empty_reg <= (cmd.out_kind == KIND_QUERY) && !min_reg;
            rem_reg   <= (cmd.out_kind == KIND_QUERY) ? OutTime'(rem_full) : '0;
            if (cmd.out_kind == KIND_NEW)
            begin
                tid_reg <= new_id;
            end
            else if (cmd.out_kind == KIND_EXIST)
            begin
                tid_reg <= id_reg[tag_idx_reg];
            end
            else if (cmd.out_kind == KIND_EXPIRED)
            begin
                tid_reg <= id_reg[min_idx_reg];
            end
            else
            begin
                tid_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            last_id_reg <= '0;
            scan_reg    <= '0;
            tag_hit_reg <= 1'b0;
            id_hit_reg  <= 1'b0;
            free_reg    <= 1'b0;
            min_reg     <= 1'b0;
            emit_reg    <= '0;
            exp_cnt_reg <= '0;
            ov_reg      <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_ticks)
            begin
                emit_reg <= '0;
            end
            else if (cmd.out_load && cmd.out_kind == KIND_EXPIRED)
            begin
                emit_reg <= emit_reg + EmitBits'(1);
            end
            // expired timers are counted on the first pass of a tick only
            if (cmd.clr_ticks)
            begin
                exp_cnt_reg <= '0;
            end
            else if (cmd.scan_step && is_tick && emit_reg == '0 && sv && sdl <= now_reg)
            begin
                exp_cnt_reg <= exp_cnt_reg + CntBits'(1);
            end
            if (cmd.do_remove)
            begin
                if (func_reg == FUNC_CANCEL)
                begin
                    valid_reg[id_idx_reg] <= 1'b0;
                end
                else
                begin
                    valid_reg[min_idx_reg] <= 1'b0;
                end
            end
            if (cmd.do_insert)
            begin
                if (repl_hit && tag_idx_reg != ins_idx)
                begin
                    valid_reg[tag_idx_reg] <= 1'b0;
                end
                valid_reg[ins_idx] <= 1'b1;
                last_id_reg <= new_id;
            end
            if (cmd.scan_clr)
            begin
                scan_reg    <= '0;
                tag_hit_reg <= 1'b0;
                id_hit_reg  <= 1'b0;
                free_reg    <= 1'b0;
                min_reg     <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (!stat.scan_done)
                begin
                    scan_reg <= scan_reg + CntBits'(1);
                end
                if (sv && tagk_reg != '0 && stag == tagk_reg)
                begin
                    tag_hit_reg <= 1'b1;
                end
                if (sv && sid == cid_reg)
                begin
                    id_hit_reg <= 1'b1;
                end
                if (!sv)
                begin
                    free_reg <= 1'b1;
                end
                if (better)
                begin
                    min_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                ov_reg   <= 1'b1;
                last_reg <= cmd.out_last;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign out_busy    = ov_reg;
    assign kind        = kind_reg;
    assign timer_id    = tid_reg;
    assign queue_empty = empty_reg;
    assign remaining   = rem_reg;
    assign last        = last_reg;

endmodule

// ----- hw/rtl/tagged_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_timer_queue
// Table of pending timers with schedule, tag keep/replace, cancel, tick, query.
// ----------------------------------------------------------------------------
// Each transaction runs one serial pass over all ENTRIES slots (one slot per
// cycle) and then acts once the output register is free; its result is
// registered, and no new transaction is accepted until this one has finished.
// A tick emits expired timers one at a time; the first pass also counts them
// to set the last flag, and each further expired timer costs a fresh pass.
module tagged_timer_queue #(
    parameter int unsigned ENTRIES   = ttq_pkg::DefEntries,
    parameter int unsigned TIME_BITS = ttq_pkg::DefTimeBits,
    parameter int unsigned TAG_BITS  = ttq_pkg::DefTagBits
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ttq_pkg::FuncBits-1:0] func,
    input  logic [TIME_BITS-1:0]         now_time,
    input  logic [TIME_BITS-1:0]         time_arg,
    input  logic [TAG_BITS-1:0]          tag_key,
    input  logic [ttq_pkg::IdBits-1:0]   cancel_id,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ttq_pkg::KindBits-1:0] kind,
    output logic [ttq_pkg::IdBits-1:0]   timer_id,
    output logic                         queue_empty,
    output logic [ttq_pkg::OutTime-1:0]  remaining,
    output logic                         last
);
    import ttq_pkg::*;

    ttq_cmd_t  cmd;
    ttq_stat_t stat;
    logic      out_busy;

    ttq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    ttq_dp #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .now_time    (now_time),
        .time_arg    (time_arg),
        .tag_key     (tag_key),
        .cancel_id   (cancel_id),
        .cmd         (cmd),
        .stat        (stat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_busy    (out_busy),
        .kind        (kind),
        .timer_id    (timer_id),
        .queue_empty (queue_empty),
        .remaining   (remaining),
        .last        (last)
    );

endmodule

// ----- hw/rtl/ttq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttq_checker
// Port-level checks for the tagged timer queue.
// ----------------------------------------------------------------------------
module ttq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [31:0] timer_id,
    input logic        queue_empty,
    input logic        last
);
    import ttq_pkg::*;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(timer_id) && $stable(kind))
        else $error("stalled result changed");

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted back to back");

    a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_QUERY |-> last && timer_id == '0)
        else $error("query result malformed");

    a_empty_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> kind == KIND_QUERY)
        else $error("empty flag on non-query");

endmodule

bind tagged_timer_queue ttq_checker u_ttq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .timer_id    (timer_id),
    .queue_empty (queue_empty),
    .last        (last)
);

// ----- tb/tagged_timer_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_timer_queue_tb
// Self-checking bench for the tagged timer queue: a behavioral timer table
// predicts every result; directed corner cases, then random schedule/cancel/
// tick/query traffic with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tagged_timer_queue_tb;
    import ttq_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [KindBits-1:0] kind;
        logic [31:0]         id;
        logic                empty;
        logic [47:0]         rem;
        logic                lst;
    } timer_result_t;

    class timer_scoreboard;
        bit          used[NSLOT];
        logic [47:0] dline[NSLOT];
        logic [31:0] tid[NSLOT];
        logic [15:0] tagv[NSLOT];
        logic [31:0] last_id = '0;
        timer_result_t pending_results[$];
        int          errors;
        int          checked;

        function void push(logic [KindBits-1:0] k, logic [31:0] id, logic e,
                           logic [47:0] r);
            timer_result_t t;
            t.kind = k; t.id = id; t.empty = e; t.rem = r; t.lst = 1'b0;
            pending_results.push_back(t);
        endfunction

        function void insert(logic [47:0] dl, logic [15:0] tg);
            int i;
            for (i = 0; i < NSLOT; i++)
                if (!used[i]) break;
            if (i == NSLOT) begin
                push(KIND_FULL, 32'd0, 1'b0, 48'd0);
                return;
            end
            last_id = last_id + 32'd1;
            if (last_id == 0) last_id = 32'd1;
            used[i] = 1; dline[i] = dl; tid[i] = last_id; tagv[i] = tg;
            push(KIND_NEW, last_id, 1'b0, 48'd0);
        endfunction

        function int tag_slot(logic [15:0] tg);
            if (tg == 0) return -1;
            for (int i = 0; i < NSLOT; i++)
                if (used[i] && tagv[i] == tg) return i;
            return -1;
        endfunction

        function logic [47:0] sat_sum(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? TMAX : s[47:0];
        endfunction

        function void note_input(logic [2:0] f, logic [47:0] now, logic [47:0] ta,
                                 logic [15:0] tg, logic [31:0] cid);
            int i, n, best, before_cnt;
            logic [47:0] r;
            before_cnt = pending_results.size();
            n = 0;
            case (f)
                FUNC_AT: insert(ta, 16'd0);
                FUNC_KEEP: begin
                    i = tag_slot(tg);
                    if (i >= 0) push(KIND_EXIST, tid[i], 1'b0, 48'd0);
                    else insert(sat_sum(now, ta), tg);
                end
                FUNC_REPLACE: begin
                    i = tag_slot(tg);
                    if (i >= 0) used[i] = 0;
                    insert(sat_sum(now, ta), tg);
                end
                FUNC_CANCEL: begin
                    for (i = 0; i < NSLOT; i++)
                        if (used[i] && tid[i] == cid) begin
                            used[i] = 0;
                            break;
                        end
                end
                FUNC_TICK: begin
                    while (n < MaxResults) begin
                        best = -1;
                        for (i = 0; i < NSLOT; i++) begin
                            if (!used[i] || dline[i] > now) continue;
                            if (best < 0 || dline[i] < dline[best] ||
                                (dline[i] == dline[best] && tid[i] < tid[best]))
                                best = i;
                        end
                        if (best < 0) break;
                        used[best] = 0;
                        push(KIND_EXPIRED, tid[best], 1'b0, 48'd0);
                        n++;
                    end
                end
                FUNC_QUERY: begin
                    best = -1;
                    r = '0;
                    for (i = 0; i < NSLOT; i++)
                        if (used[i] && (best < 0 || dline[i] < dline[best])) best = i;
                    if (best >= 0 && dline[best] > now) r = dline[best] - now;
                    push(KIND_QUERY, 32'd0, (best < 0), r);
                end
                default: ;
            endcase
            if (pending_results.size() > before_cnt)
                pending_results[pending_results.size()-1].lst = 1'b1;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        endtask

        task check(logic [KindBits-1:0] k, logic [31:0] id, logic e,
                   logic [47:0] r, logic l);
            timer_result_t x;
            if (pending_results.size() == 0) begin
                report("unexpected result kind", 64'(k), 64'd0);
                return;
            end
            x = pending_results.pop_front();
            checked++;
            if (k !== x.kind) report("kind", 64'(k), 64'(x.kind));
            if (id !== x.id) report("timer_id", 64'(id), 64'(x.id));
            if (e !== x.empty) report("queue_empty", 64'(e), 64'(x.empty));
            if (r !== x.rem) report("remaining", 64'(r), 64'(x.rem));
            if (l !== x.lst) report("last", 64'(l), 64'(x.lst));
        endtask

        function int live_count();
            int c;
            c = 0;
            for (int i = 0; i < NSLOT; i++) c += used[i];
            return c;
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                in_valid = 0;
    logic                in_stall;
    logic [2:0]          func = 0;
    logic [47:0]         now_time = 0;
    logic [47:0]         time_arg = 0;
    logic [15:0]         tag_key = 0;
    logic [31:0]         cancel_id = 0;
    logic                out_valid;
    logic                out_stall = 0;
    logic [KindBits-1:0] kind;
    logic [31:0]         timer_id;
    logic                queue_empty;
    logic [47:0]         remaining;
    logic                last;

    timer_scoreboard sb = new();
    logic [47:0] clock_now = 1000;
    bit  stall_enable = 1;
    bit  holdoff = 0;
    bit  idle_enable = 1;
    int  cycles = 0;
    int  n_sent = 0;

    tagged_timer_queue dut (.*);

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
            sb.check(kind, timer_id, queue_empty, remaining, last);
    end

    // output back-pressure: random bursts, plus a long hold-off on request
    initial begin
        int len;
        forever begin
            @(negedge clk);
            if (holdoff) begin
                out_stall <= 1;
            end else if (stall_enable && $urandom_range(0, 5) == 0) begin
                len = $urandom_range(1, 13);
                out_stall <= 1;
                repeat (len) @(negedge clk);
                out_stall <= 0;
            end else begin
                out_stall <= 0;
            end
        end
    end

    task automatic send(logic [2:0] f, logic [47:0] ta, logic [15:0] tg, logic [31:0] cid);
        @(negedge clk);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        func <= f; now_time <= clock_now; time_arg <= ta; tag_key <= tg; cancel_id <= cid;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(f, clock_now, ta, tg, cid);
        n_sent++;
        @(negedge clk);
        in_valid <= 0;
    endtask

    function automatic logic [31:0] some_live_id();
        for (int k = 0; k < 4; k++) begin
            int i;
            i = $urandom_range(0, NSLOT - 1);
            if (sb.used[i]) return sb.tid[i];
        end
        return $urandom;
    endfunction

    task automatic random_item();
        int r;
        logic [47:0] ta;
        logic [15:0] tg;
        r = $urandom_range(0, 99);
        ta = 48'($urandom_range(0, 60));
        if ($urandom_range(0, 15) == 0) ta = 48'({$urandom, $urandom});
        tg = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        if ($urandom_range(0, 20) == 0) tg = 16'($urandom);
        if ($urandom_range(0, 3) == 0) clock_now = clock_now + 48'($urandom_range(0, 30));
        if (r < 15) send(FUNC_AT, clock_now + 48'($urandom_range(0, 60)), tg, $urandom);
        else if (r < 33) send(FUNC_KEEP, ta, tg, $urandom);
        else if (r < 50) send(FUNC_REPLACE, ta, tg, $urandom);
        else if (r < 62) send(FUNC_CANCEL, ta, tg, some_live_id());
        else if (r < 82) send(FUNC_TICK, ta, tg, $urandom);
        else if (r < 97) send(FUNC_QUERY, ta, tg, $urandom);
        else send(3'($urandom_range(6, 7)), 48'({$urandom, $urandom}), 16'($urandom),
                  $urandom);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending_results.size() != 0 && guard < 20000) begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: empty table, extremes, tags, saturation, full table
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0);
        send(FUNC_CANCEL, 0, 0, 32'hFFFF_FFFF);
        send(FUNC_AT, TMAX, 16'hFFFF, 32'hFFFF_FFFF);
        send(FUNC_AT, 0, 0, 0);
        send(FUNC_KEEP, TMAX, 16'hFFFF, 0);
        send(FUNC_KEEP, 5, 16'hFFFF, 0);
        send(FUNC_REPLACE, 7, 16'hFFFF, 0);
        send(FUNC_KEEP, 7, 16'h0000, 0);
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_CANCEL, 0, 0, 32'd3);
        send(3'd6, TMAX, 16'hFFFF, 32'hFFFF_FFFF);
        send(3'd7, 0, 0, 0);
        for (int k = 0; k < 14; k++) send(FUNC_AT, clock_now + 48'(5 - (k % 3)), 0, 0);
        send(FUNC_REPLACE, 3, 16'h0001, 0);
        send(FUNC_KEEP, 3, 16'h0002, 0);
        clock_now = 48'hFFFF_FFFF_FFF0;
        send(FUNC_QUERY, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0);
        send(FUNC_TICK, 0, 0, 0);
        drain();
        clock_now = 0;
        send(FUNC_CANCEL, 0, 0, 32'd1);

        // long output hold-off while the sender keeps offering
        holdoff = 1;
        fork
            begin
                repeat (300) @(negedge clk);
                holdoff = 0;
            end
            for (int k = 0; k < 12; k++) random_item();
        join

        while (n_sent < 150) begin
            if (n_sent > 125) begin
                idle_enable = 0;
                stall_enable = 0;
            end
            random_item();
        end
        drain();

        $display("%0d transactions sent, %0d results checked, %0d timers still pending",
                 n_sent, sb.checked, sb.live_count());
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[tagged_timer_queue] OK");
        else
            $display("[tagged_timer_queue] ERROR");
        $finish;
    end

    initial begin
        wait (cycles >= 400000);
        $display("timeout after %0d cycles", cycles);
        $display("[tagged_timer_queue] ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ttq_pkg.sv
hw/rtl/ttq_ctrl.sv
hw/rtl/ttq_dp.sv
hw/rtl/tagged_timer_queue.sv
hw/rtl/ttq_checker.sv
tb/tagged_timer_queue_tb.sv
